>>> hdl/gbn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants and types for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbn_pkg;
	localparam int MAX_BOXES  = 64;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_BOXES);
	localparam int CNT_W      = $clog2(MAX_BOXES + 1);
	localparam int AREA_W     = 2 * COORD_BITS;
	localparam int UNI_W      = AREA_W + 1;
	localparam logic [15:0] THR_RESET = 16'd32768;

	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] top;
		logic [COORD_BITS-1:0] right;
		logic [COORD_BITS-1:0] bottom;
	} box_t;

	// queue entry from front to back: a box (or a drop marker) per beat
	typedef struct packed {
		box_t        box;
		logic [15:0] score;
		logic        keep;
		logic        last;
	} qent_t;

	function automatic logic [COORD_BITS-1:0] span(input logic [COORD_BITS-1:0] lo,
		input logic [COORD_BITS-1:0] hi);
		span = (hi > lo) ? hi - lo : '0;
	endfunction
endpackage

>>> hdl/gbn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_front
// Accepts input beats and classifies each as stored box or dropped box.
// ----------------------------------------------------------------------------
module gbn_front import gbn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  box_t        in_box,
	input  logic [15:0] in_score,
	input  logic        in_last,
	output logic        q_valid,
	input  logic        q_ready,
	output qent_t       q_data
);
	logic [CNT_W-1:0] count_q;
	qent_t            ent_q;
	logic             full_q;

	assign in_ready = !full_q || q_ready;
	assign q_valid  = full_q;
	assign q_data   = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			full_q  <= 1'b0;
		end else begin
			if (q_ready && full_q) full_q <= 1'b0;
			if (in_valid && in_ready) begin
				full_q <= 1'b1;
				if (in_last) count_q <= '0;
				else if (count_q != CNT_W'(MAX_BOXES)) count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ent_q.box   <= in_box;
			ent_q.score <= in_score;
			ent_q.keep  <= (count_q != CNT_W'(MAX_BOXES));
			ent_q.last  <= in_last;
		end
	end
endmodule

>>> hdl/gbn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_back
// Stores boxes and runs the greedy pick and suppress passes on end of set.
// ----------------------------------------------------------------------------
module gbn_back import gbn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] thr,
	input  logic        q_valid,
	output logic        q_ready,
	input  qent_t       q_data,
	output logic        o_valid,
	input  logic        o_ready,
	output box_t        o_box,
	output logic [15:0] o_score,
	output logic        o_last,
	output logic        o_ovf
);
	typedef enum logic [2:0] {LOAD, PICK, PWAIT, SUPP, EMIT} st_t;
	st_t st_q;

	box_t        cmem [MAX_BOXES];
	logic [15:0] smem [MAX_BOXES];
	logic [MAX_BOXES-1:0] live_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 ovf_q;
	logic [CNT_W-1:0]     scan_q;
	logic [IDX_W-1:0]     best_q;
	logic                 found_q;
	logic [15:0]          bsc_q;
	box_t                 bbox_q;
	logic [AREA_W-1:0]    barea_q;
	// pipeline for the suppress pass
	box_t                 rbox_s1;
	logic [15:0]          rsc_s1;
	logic [IDX_W-1:0]     ridx_s1;
	logic                 rv_s1;
	logic [AREA_W-1:0]    inter_s2, area_s2;
	logic [IDX_W-1:0]     idx_s2;
	logic                 v_s2;
	logic [UNI_W-1:0]     uni_s3;
	logic [AREA_W-1:0]    inter_s3;
	logic [IDX_W-1:0]     idx_s3;
	logic                 v_s3;
	logic [UNI_W+16-1:0]  rhs_s4;
	logic [AREA_W+16-1:0] lhs_s4;
	logic                 uz_s4;
	logic [IDX_W-1:0]     idx_s4;
	logic                 v_s4;

	logic [IDX_W-1:0] rd_idx;
	assign rd_idx = scan_q[IDX_W-1:0];
	assign q_ready = (st_q == LOAD);

	always_ff @(posedge clk) begin
		if (q_valid && q_ready && q_data.keep) begin
			cmem[cnt_q[IDX_W-1:0]] <= q_data.box;
			smem[cnt_q[IDX_W-1:0]] <= q_data.score;
		end
		rbox_s1 <= cmem[rd_idx];
		rsc_s1  <= smem[rd_idx];
		ridx_s1 <= rd_idx;
	end

	logic [COORD_BITS-1:0] iw, ih, aw, ah;
	always_comb begin
		iw = span((bbox_q.left > rbox_s1.left) ? bbox_q.left : rbox_s1.left,
			(bbox_q.right < rbox_s1.right) ? bbox_q.right : rbox_s1.right);
		ih = span((bbox_q.top > rbox_s1.top) ? bbox_q.top : rbox_s1.top,
			(bbox_q.bottom < rbox_s1.bottom) ? bbox_q.bottom : rbox_s1.bottom);
		aw = span(rbox_s1.left, rbox_s1.right);
		ah = span(rbox_s1.top, rbox_s1.bottom);
	end

	always_ff @(posedge clk) begin
		inter_s2 <= AREA_W'(iw) * AREA_W'(ih);
		area_s2  <= AREA_W'(aw) * AREA_W'(ah);
		idx_s2   <= ridx_s1;
		uni_s3   <= UNI_W'(area_s2) + UNI_W'(barea_q) - UNI_W'(inter_s2);
		inter_s3 <= inter_s2;
		idx_s3   <= idx_s2;
		lhs_s4   <= {inter_s3, 16'd0};
		rhs_s4   <= (UNI_W+16)'(uni_s3) * (UNI_W+16)'(thr);
		uz_s4    <= (uni_s3 == '0);
		idx_s4   <= idx_s3;
	end

	logic kill;
	assign kill = v_s4 && !uz_s4 && ((AREA_W+17)'(lhs_s4) > (AREA_W+17)'(rhs_s4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LOAD; live_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
			scan_q <= '0; found_q <= 1'b0; o_valid <= 1'b0;
			rv_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s2 <= rv_s1 && st_q == SUPP;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			rv_s1 <= 1'b0;
			if (kill) live_q[idx_s4] <= 1'b0;
			unique case (st_q)
				LOAD: if (q_valid) begin
					if (q_data.keep) begin
						live_q[cnt_q[IDX_W-1:0]] <= 1'b1;
					end
					if (q_data.keep && !q_data.last) cnt_q <= cnt_q + 1'b1;
					if (!q_data.keep) ovf_q <= 1'b1;
					if (q_data.last) begin
						if (q_data.keep) cnt_q <= cnt_q + 1'b1;
						st_q <= PICK; scan_q <= '0; found_q <= 1'b0;
					end
				end
				PICK: begin
					// scan one entry a cycle, read data lands in the cycle after
					if (scan_q < cnt_q) begin
						rv_s1  <= live_q[rd_idx];
						scan_q <= scan_q + 1'b1;
					end else if (!rv_s1) begin
						st_q <= PWAIT;
					end
					if (rv_s1 && (!found_q || rsc_s1 > bsc_q)) begin
						found_q <= 1'b1; best_q <= ridx_s1; bsc_q <= rsc_s1;
						bbox_q <= rbox_s1;
					end
				end
				PWAIT: begin
					if (!found_q) begin
						st_q <= LOAD; cnt_q <= '0; ovf_q <= 1'b0; live_q <= '0;
					end else begin
						live_q[best_q] <= 1'b0;
						barea_q <= AREA_W'(span(bbox_q.left, bbox_q.right)) *
							AREA_W'(span(bbox_q.top, bbox_q.bottom));
						scan_q <= '0; st_q <= SUPP;
					end
				end
				SUPP: begin
					if (scan_q < cnt_q) begin
						rv_s1  <= live_q[rd_idx];
						scan_q <= scan_q + 1'b1;
					end else if (!rv_s1 && !v_s2 && !v_s3 && !v_s4) begin
						o_box <= bbox_q; o_score <= bsc_q; o_ovf <= ovf_q;
						o_last <= (live_q == '0); o_valid <= 1'b1;
						st_q <= EMIT;
					end
				end
				EMIT: if (o_ready) begin
					o_valid <= 1'b0;
					scan_q <= '0; found_q <= 1'b0;
					st_q <= PICK;
				end
				default: st_q <= LOAD;
			endcase
		end
	end
endmodule

>>> hdl/greedy_box_nms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_nms
// Greedy IoU non-maximum suppression over a stored set of boxes.
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata box corners+score, tlast last_box
// m_axis   out  tdata kept corners+score, tlast last_kept, tuser overflow
// cfg      in   iou_threshold
// Boxes load one per cycle while the store is in its load state. Per kept
// box a pick pass and a suppress pass each walk all N stored boxes through
// the memory read port. A final pick pass with no live box ends the set.
// Reset clears counts, live bits and flags and restores the threshold.
// Output holds while m_axis_tready is low; while a set is processed the
// input takes one beat of the next set, then stalls until the set is done.
// ----------------------------------------------------------------------------
module greedy_box_nms import gbn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // left, top, right, bottom, score
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // left, top, right, bottom, score
	output logic        m_axis_tlast,
	output logic        m_axis_tuser   // overflow
);
	logic [15:0] thr_q;
	logic qv, qr;
	qent_t qd;
	box_t ib, ob;
	logic [15:0] osc;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THR_RESET;
		else if (cfg_valid) thr_q <= cfg_data;
	end

	assign ib.left   = s_axis_tdata[COORD_BITS-1:0];
	assign ib.top    = s_axis_tdata[16 +: COORD_BITS];
	assign ib.right  = s_axis_tdata[32 +: COORD_BITS];
	assign ib.bottom = s_axis_tdata[48 +: COORD_BITS];

	gbn_front u_front (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_box(ib), .in_score(s_axis_tdata[79:64]), .in_last(s_axis_tlast),
		.q_valid(qv), .q_ready(qr), .q_data(qd));

	gbn_back u_back (.clk, .arst_n, .thr(thr_q), .q_valid(qv), .q_ready(qr), .q_data(qd),
		.o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_box(ob), .o_score(osc),
		.o_last(m_axis_tlast), .o_ovf(m_axis_tuser));

	assign m_axis_tdata = {osc, 16'(ob.bottom), 16'(ob.right), 16'(ob.top), 16'(ob.left)};
endmodule

>>> hdl/gbn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks for greedy_box_nms.
// ----------------------------------------------------------------------------
module gbn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser,
	input logic        s_axis_tready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");
	a_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output sideband changed while stalled");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(s_axis_tready) && !$isunknown(m_axis_tvalid))
		else $error("handshake signal unknown");
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
		|-> m_axis_tuser == $past(m_axis_tuser))
		else $error("overflow flag changed within a set");
endmodule

bind greedy_box_nms gbn_checker u_chk (.clk, .arst_n, .m_axis_tvalid, .m_axis_tready,
	.m_axis_tdata, .m_axis_tlast, .m_axis_tuser, .s_axis_tready);

>>> bench/tb_greedy_box_nms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_box_nms
// Self-checking bench for the greedy box suppression block. Box sets are
// streamed in, the kept boxes are predicted with a bit-accurate software
// copy of the greedy pick/suppress loop, and every output beat is compared
// with the oldest predicted kept box. Threshold changes happen between sets.
// ----------------------------------------------------------------------------
module tb_greedy_box_nms;
	import gbn_pkg::*;

	typedef struct packed {
		logic [15:0] left, top, right, bottom, score;
		logic        last;
	} box_beat_t;

	typedef struct packed {
		logic [15:0] left, top, right, bottom, score;
		logic        last, ovf;
	} kept_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;  // left, top, right, bottom, score
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;       // left, top, right, bottom, score
	logic        m_axis_tlast;
	logic        m_axis_tuser;       // overflow

	greedy_box_nms dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [15:0] thr = THR_RESET;
	box_beat_t   set_boxes[$];
	logic        set_ovf = 1'b0;
	kept_beat_t  kept_q[$];

	box_beat_t   pending_q[$];
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_recv = 1'b0;
	int          errors = 0;
	int          quiet_cycles = 0;

	function automatic logic [15:0] extent(logic [15:0] lo, logic [15:0] hi);
		return hi > lo ? hi - lo : 16'd0;
	endfunction

	function automatic bit suppresses(box_beat_t a, box_beat_t b);
		logic [63:0] w, h, inter, uni;
		w = extent(a.left > b.left ? a.left : b.left, a.right < b.right ? a.right : b.right);
		h = extent(a.top > b.top ? a.top : b.top, a.bottom < b.bottom ? a.bottom : b.bottom);
		inter = w * h;
		uni = extent(a.left, a.right) * extent(a.top, a.bottom)
			+ extent(b.left, b.right) * extent(b.top, b.bottom) - inter;
		if (uni == 0)
			return 1'b0;
		return (inter << 16) > {48'd0, thr} * uni;
	endfunction

	// load one box; on the last one run greedy suppression into kept_q
	task automatic predict_box(box_beat_t b);
		bit alive[$];
		int best, n;
		kept_beat_t k;
		if (set_boxes.size() < MAX_BOXES)
			set_boxes = {set_boxes, b};
		else
			set_ovf = 1'b1;
		if (!b.last)
			return;
		n = set_boxes.size();
		for (int i = 0; i < n; i++)
			alive = {alive, 1'b1};
		forever begin
			best = -1;
			for (int i = 0; i < n; i++)
				if (alive[i] && (best < 0 || set_boxes[i].score > set_boxes[best].score))
					best = i;
			if (best < 0)
				break;
			alive[best] = 1'b0;
			for (int i = 0; i < n; i++)
				if (alive[i] && suppresses(set_boxes[best], set_boxes[i]))
					alive[i] = 1'b0;
			k.left = set_boxes[best].left;
			k.top = set_boxes[best].top;
			k.right = set_boxes[best].right;
			k.bottom = set_boxes[best].bottom;
			k.score = set_boxes[best].score;
			k.ovf = set_ovf;
			k.last = 1'b1;
			for (int i = 0; i < n; i++)
				if (alive[i])
					k.last = 1'b0;
			kept_q = {kept_q, k};
		end
		set_boxes.delete();
		set_ovf = 1'b0;
	endtask

	// append one beat to the pending stimulus
	task automatic add_box(box_beat_t b);
		pending_q = {pending_q, b};
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					box_beat_t b;
					b = pending_q.pop_front();
					s_axis_tdata <= {b.score, b.bottom, b.right, b.top, b.left};
					s_axis_tlast <= b.last;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on accepted input, check accepted output
	always @(posedge clk) begin
		box_beat_t  b;
		kept_beat_t e;
		bit         moved;
		if (arst_n) begin
			moved = 1'b0;
			if (s_axis_tvalid && s_axis_tready) begin
				moved = 1'b1;
				{b.score, b.bottom, b.right, b.top, b.left} = s_axis_tdata;
				b.last = s_axis_tlast;
				predict_box(b);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				if (kept_q.size() == 0) begin
					$error("unexpected kept box %h", m_axis_tdata);
					errors++;
				end else begin
					e = kept_q.pop_front();
					if (m_axis_tdata[15:0] !== e.left) begin
						$error("kept_left exp %0d got %0d", e.left, m_axis_tdata[15:0]);
						errors++;
					end
					if (m_axis_tdata[31:16] !== e.top) begin
						$error("kept_top exp %0d got %0d", e.top, m_axis_tdata[31:16]);
						errors++;
					end
					if (m_axis_tdata[47:32] !== e.right) begin
						$error("kept_right exp %0d got %0d", e.right, m_axis_tdata[47:32]);
						errors++;
					end
					if (m_axis_tdata[63:48] !== e.bottom) begin
						$error("kept_bottom exp %0d got %0d", e.bottom, m_axis_tdata[63:48]);
						errors++;
					end
					if (m_axis_tdata[79:64] !== e.score) begin
						$error("kept_score exp %0d got %0d", e.score, m_axis_tdata[79:64]);
						errors++;
					end
					if (m_axis_tlast !== e.last) begin
						$error("last_kept exp %0d got %0d", e.last, m_axis_tlast);
						errors++;
					end
					if (m_axis_tuser !== e.ovf) begin
						$error("overflow exp %0d got %0d", e.ovf, m_axis_tuser);
						errors++;
					end
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (quiet_cycles > 20000) begin
			$display("FAIL greedy_box_nms");
			$finish;
		end
	end

	function automatic box_beat_t mk(int l, int t, int r, int btm, int s, bit last);
		box_beat_t b;
		b.left = 16'(l);
		b.top = 16'(t);
		b.right = 16'(r);
		b.bottom = 16'(btm);
		b.score = 16'(s);
		b.last = last;
		return b;
	endfunction

	// random box, mostly near a cluster center so that overlaps are common
	function automatic box_beat_t rand_box(int cx, int cy, bit last);
		box_beat_t b;
		int l, t;
		if ($urandom_range(9) == 0) begin
			b = mk($urandom, $urandom, $urandom, $urandom, $urandom, last);
		end else begin
			l = cx + $urandom_range(40);
			t = cy + $urandom_range(40);
			b = mk(l, t, l + $urandom_range(80), t + $urandom_range(80),
				$urandom_range(3) == 0 ? 16'h8000 : $urandom, last);
		end
		return b;
	endfunction

	task automatic drain();
		while (pending_q.size() > 0 || s_axis_tvalid || kept_q.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_thr(logic [15:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		thr = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_set(int n);
		int cx, cy;
		cx = $urandom_range(65000);
		cy = $urandom_range(65000);
		for (int i = 0; i < n; i++)
			add_box(rand_box(cx < 65400 ? cx : 0, cy < 65400 ? cy : 0, i == n - 1));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, ties, zero-area boxes, identical and disjoint boxes
		add_box(mk(0, 0, 65535, 65535, 65535, 0));
		add_box(mk(0, 0, 65535, 65535, 65535, 0));
		add_box(mk(65535, 65535, 0, 0, 0, 0));
		add_box(mk(10, 10, 10, 10, 100, 0));
		add_box(mk(10, 10, 20, 20, 100, 0));
		add_box(mk(15, 15, 25, 25, 200, 0));
		add_box(mk(100, 100, 110, 110, 200, 1));
		drain();
		add_box(mk(16'h5555, 16'haaaa, 16'haaaa, 16'hffff, 16'h5555, 0));
		add_box(mk(16'haaaa, 16'h5555, 16'hffff, 16'haaaa, 16'haaaa, 0));
		add_box(mk(5, 5, 5, 5, 7, 1));
		drain();
		add_box(mk(0, 0, 0, 0, 0, 1));
		drain();
		write_thr(16'd0);
		add_box(mk(0, 0, 10, 10, 5, 0));
		add_box(mk(9, 9, 20, 20, 6, 0));
		add_box(mk(30, 30, 40, 40, 7, 1));
		drain();
		write_thr(16'hffff);
		add_box(mk(0, 0, 10, 10, 5, 0));
		add_box(mk(0, 0, 10, 10, 5, 1));
		drain();

		// overflow: 66 boxes into a 64-entry store, so the last box is dropped
		write_thr(16'd16384);
		for (int i = 0; i < 66; i++)
			add_box(mk(i * 500, 0, i * 500 + 400, 400, $urandom, i == 65));
		drain();

		// random sets across thresholds and idling phases
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 64 : (ph == 3) ? 21 : 0;
			recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 21 : 0;
			write_thr(ph == 0 ? 16'd0 : ph == 1 ? 16'hffff : 16'($urandom));
			for (int s = 0; s < 2; s++)
				queue_set($urandom_range(1, 6));
			drain();
		end

		// long receiver hold-off while the sender keeps offering beats
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_thr(16'd32768);
		hold_recv = 1'b1;
		queue_set(8);
		queue_set(6);
		repeat (800) @(posedge clk);
		hold_recv = 1'b0;
		drain();

		if (errors == 0)
			$display("PASS greedy_box_nms");
		else
			$display("FAIL greedy_box_nms");
		$finish;
	end
endmodule

>>> filelist.f
hdl/gbn_pkg.sv
hdl/gbn_front.sv
hdl/gbn_back.sv
hdl/greedy_box_nms.sv
hdl/gbn_checker.sv
bench/tb_greedy_box_nms.sv
